// ===== design/affine_3x4_inverse_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the affine 3x4 inverse block
// Concurrent checks that are compiled out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef AFFINE_3X4_INVERSE_DEFINES_SVH
`define AFFINE_3X4_INVERSE_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define AFF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define AFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define AFF_ASSERT_SAME(label, ante, cons)
`define AFF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/aff_pkg.sv =====
// ----------------------------------------------------------------------------
// aff_pkg
// Widths, constants, types and helpers shared by the affine inverse block.
// ----------------------------------------------------------------------------
`default_nettype none
package aff_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int DIM       = 3;
    localparam int LANES     = DIM + 1;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ADJ_W     = PROD_W + 1;
    localparam int PART_W    = 2 * ELEM_W + 1;
    localparam int TERM_W    = ELEM_W + ADJ_W;
    localparam int DET_W     = TERM_W + 2;
    localparam int NUM_COL_W = ADJ_W + 2 * FRAC_BITS;
    localparam int NUM_SFT_W = DET_W + FRAC_BITS;
    localparam int NUM_W     = (NUM_COL_W > NUM_SFT_W) ? NUM_COL_W : NUM_SFT_W;
    localparam int QUO_W     = ELEM_W + 1;
    localparam int CMP_W     = ((NUM_W > DET_W + QUO_W) ? NUM_W : DET_W + QUO_W) + 1;

    localparam logic [1:0] LAST_ROW = 2'd2;
    localparam logic [ELEM_W-1:0] POS_SAT = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] NEG_SAT = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        logic [DIM-1:0][ELEM_W-1:0]         m0;
        logic [DIM-1:0][ELEM_W-1:0]         s;
        logic [DIM-1:0][DIM-1:0][ADJ_W-1:0] adj;
    } cof_item_t;

    typedef struct packed {
        logic [DIM-1:0][DIM-1:0][ADJ_W-1:0] adj;
        logic [DET_W-1:0]                   det;
        logic [DIM-1:0][DET_W-1:0]          tsum;
        logic                               sing;
    } det_item_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0]            ovf;
        logic [DET_W-1:0]            den;
        logic [1:0]                  row;
        logic                        sing;
    } div_stage_t;

    typedef struct packed {
        logic [LANES-1:0][ELEM_W-1:0] mag;
        logic [LANES-1:0]             sat;
        logic [LANES-1:0]             neg;
        logic [1:0]                   row;
        logic                         sing;
    } round_t;

    // Index i advanced by k, modulo the matrix dimension.
    function automatic int idx3(input int i, input int k);
        int j;
        j = i + k;
        if (j >= DIM) begin
            j = j - DIM;
        end
        return j;
    endfunction

endpackage
`default_nettype wire

// ===== design/aff_cofactor.sv =====
// ----------------------------------------------------------------------------
// aff_cofactor
// Two stages: the eighteen 2x2 minor products, then the nine cofactors.
// ----------------------------------------------------------------------------
`default_nettype none
module aff_cofactor (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               adv,
    input  logic                                               in_valid,
    input  logic [aff_pkg::DIM*aff_pkg::DIM-1:0][aff_pkg::ELEM_W-1:0] elems,
    input  logic [aff_pkg::DIM-1:0][aff_pkg::ELEM_W-1:0]       shifts,
    output logic                                               out_valid,
    output aff_pkg::cof_item_t                                 out_item
);
    import aff_pkg::*;

    logic signed [PROD_W-1:0] prod_reg  [DIM][DIM][2];
    logic signed [PROD_W-1:0] prod_next [DIM][DIM][2];
    logic [DIM-1:0][ELEM_W-1:0] m0_reg;
    logic [DIM-1:0][ELEM_W-1:0] s_reg;
    logic       v1_reg;
    logic       v2_reg;
    cof_item_t  item_reg;
    cof_item_t  item_next;

    // adj[r][c] is the cofactor of element (c, r).
    always_comb
    begin
        int r1;
        int r2;
        int c1;
        int c2;
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                r1 = idx3(c, 1);
                r2 = idx3(c, 2);
                c1 = idx3(r, 1);
                c2 = idx3(r, 2);
                prod_next[r][c][0] = $signed(elems[r1*DIM+c1]) * $signed(elems[r2*DIM+c2]);
                prod_next[r][c][1] = $signed(elems[r1*DIM+c2]) * $signed(elems[r2*DIM+c1]);
            end
        end
    end

    always_comb
    begin
        item_next.m0 = m0_reg;
        item_next.s  = s_reg;
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                item_next.adj[r][c] = ADJ_W'(prod_reg[r][c][0]) - ADJ_W'(prod_reg[r][c][1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            m0_reg   <= elems[DIM-1:0];
            s_reg    <= shifts;
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;
endmodule
`default_nettype wire

// ===== design/aff_det.sv =====
// ----------------------------------------------------------------------------
// aff_det
// Three stages: split partial products, recombined terms, determinant and
// translation sums.
// ----------------------------------------------------------------------------
`default_nettype none
module aff_det (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  aff_pkg::cof_item_t in_item,
    output logic               out_valid,
    output aff_pkg::det_item_t out_item
);
    import aff_pkg::*;

    logic signed [PART_W-1:0] dlo_reg [DIM];
    logic signed [PART_W-1:0] dhi_reg [DIM];
    logic signed [PART_W-1:0] tlo_reg [DIM][DIM];
    logic signed [PART_W-1:0] thi_reg [DIM][DIM];
    logic signed [PART_W-1:0] dlo_next [DIM];
    logic signed [PART_W-1:0] dhi_next [DIM];
    logic signed [PART_W-1:0] tlo_next [DIM][DIM];
    logic signed [PART_W-1:0] thi_next [DIM][DIM];
    logic signed [TERM_W-1:0] dterm_reg [DIM];
    logic signed [TERM_W-1:0] tterm_reg [DIM][DIM];
    logic signed [TERM_W-1:0] dterm_next [DIM];
    logic signed [TERM_W-1:0] tterm_next [DIM][DIM];
    logic [DIM-1:0][DIM-1:0][ADJ_W-1:0] adj3_reg;
    logic [DIM-1:0][DIM-1:0][ADJ_W-1:0] adj4_reg;
    logic      v3_reg;
    logic      v4_reg;
    logic      v5_reg;
    det_item_t item_reg;
    det_item_t item_next;

    // Each 32 x 65 product is split into a low unsigned and a high signed half.
    always_comb
    begin
        logic [ADJ_W-1:0] a;
        for (int c = 0; c < DIM; c++)
        begin
            a = in_item.adj[c][0];
            dlo_next[c] = $signed(in_item.m0[c]) * $signed({1'b0, a[ELEM_W-1:0]});
            dhi_next[c] = $signed(in_item.m0[c]) * $signed(a[ADJ_W-1:ELEM_W]);
            for (int r = 0; r < DIM; r++)
            begin
                a = in_item.adj[r][c];
                tlo_next[r][c] = $signed(in_item.s[c]) * $signed({1'b0, a[ELEM_W-1:0]});
                thi_next[r][c] = $signed(in_item.s[c]) * $signed(a[ADJ_W-1:ELEM_W]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < DIM; c++)
        begin
            dterm_next[c] = (TERM_W'(dhi_reg[c]) <<< ELEM_W) + TERM_W'(dlo_reg[c]);
            for (int r = 0; r < DIM; r++)
            begin
                tterm_next[r][c] = (TERM_W'(thi_reg[r][c]) <<< ELEM_W)
                                 + TERM_W'(tlo_reg[r][c]);
            end
        end
    end

    always_comb
    begin
        logic signed [DET_W-1:0] acc;
        acc = '0;
        for (int c = 0; c < DIM; c++)
        begin
            acc = acc + DET_W'(dterm_reg[c]);
        end
        item_next.det  = acc;
        item_next.sing = (acc == '0);
        item_next.adj  = adj4_reg;
        for (int r = 0; r < DIM; r++)
        begin
            acc = '0;
            for (int c = 0; c < DIM; c++)
            begin
                acc = acc + DET_W'(tterm_reg[r][c]);
            end
            item_next.tsum[r] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlo_reg   <= dlo_next;
            dhi_reg   <= dhi_next;
            tlo_reg   <= tlo_next;
            thi_reg   <= thi_next;
            adj3_reg  <= in_item.adj;
            dterm_reg <= dterm_next;
            tterm_reg <= tterm_next;
            adj4_reg  <= adj3_reg;
            item_reg  <= item_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = item_reg;
endmodule
`default_nettype wire

// ===== design/aff_row_seq.sv =====
// ----------------------------------------------------------------------------
// aff_row_seq
// Holds one transform and issues its three rows, one per beat, as
// sign and magnitude numerators over the determinant magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module aff_row_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  aff_pkg::det_item_t  in_item,
    output logic                front_adv,
    output logic                out_valid,
    output aff_pkg::div_stage_t out_stage
);
    import aff_pkg::*;

    det_item_t  hold_reg;
    logic       hvld_reg;
    logic       hvld_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       take;
    logic       d0v_reg;
    div_stage_t d0_reg;
    div_stage_t d0_next;

    // A new transform may load while the last row of the held one issues.
    assign take      = !hvld_reg || (cnt_reg == LAST_ROW);
    assign front_adv = adv && take;

    always_comb
    begin
        hvld_next = hvld_reg;
        cnt_next  = cnt_reg;
        if (adv)
        begin
            if (in_valid && take)
            begin
                hvld_next = 1'b1;
                cnt_next  = 2'd0;
            end
            else if (hvld_reg)
            begin
                if (cnt_reg == LAST_ROW)
                begin
                    hvld_next = 1'b0;
                    cnt_next  = 2'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        logic [ADJ_W-1:0] a;
        logic [ADJ_W-1:0] amag;
        logic [DET_W-1:0] t;
        logic [DET_W-1:0] tmag;
        logic [DET_W-1:0] d;
        d = hold_reg.det;
        d0_next.den  = d[DET_W-1] ? (~d + 1'b1) : d;
        d0_next.row  = cnt_reg;
        d0_next.sing = hold_reg.sing;
        d0_next.quo  = '0;
        d0_next.ovf  = '0;
        for (int c = 0; c < DIM; c++)
        begin
            a    = hold_reg.adj[cnt_reg][c];
            amag = a[ADJ_W-1] ? (~a + 1'b1) : a;
            d0_next.rem[c] = NUM_W'(amag) << (2 * FRAC_BITS);
            d0_next.neg[c] = a[ADJ_W-1] ^ d[DET_W-1];
        end
        // The translation numerator is the negated sum, so its sign flips.
        t    = hold_reg.tsum[cnt_reg];
        tmag = t[DET_W-1] ? (~t + 1'b1) : t;
        d0_next.rem[DIM] = NUM_W'(tmag) << FRAC_BITS;
        d0_next.neg[DIM] = ~t[DET_W-1] ^ d[DET_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvld_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            d0v_reg  <= 1'b0;
        end
        else
        begin
            hvld_reg <= hvld_next;
            cnt_reg  <= cnt_next;
            if (adv)
            begin
                d0v_reg <= hvld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv && in_valid)
        begin
            hold_reg <= in_item;
        end
        if (adv)
        begin
            d0_reg <= d0_next;
        end
    end

    assign out_valid = d0v_reg;
    assign out_stage = d0_reg;
endmodule
`default_nettype wire

// ===== design/aff_divider.sv =====
// ----------------------------------------------------------------------------
// aff_divider
// Four-lane pipelined restoring divider with one quotient bit per stage,
// round to nearest, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module aff_divider (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic                                          in_valid,
    input  aff_pkg::div_stage_t                           in_stage,
    output logic                                          out_valid,
    output logic [1:0]                                    out_row,
    output logic [aff_pkg::LANES-1:0][aff_pkg::ELEM_W-1:0] out_vals,
    output logic                                          out_sing
);
    import aff_pkg::*;

    div_stage_t st_reg [QUO_W+1];
    logic       vld_reg [QUO_W+1];
    div_stage_t pre_next;
    round_t     rnd_reg;
    round_t     rnd_next;
    logic       rnd_v_reg;
    logic       ov_reg;
    logic [1:0] orow_reg;
    logic       osing_reg;
    logic [LANES-1:0][ELEM_W-1:0] oval_reg;
    logic [LANES-1:0][ELEM_W-1:0] oval_next;

    // A quotient of 2^QUO_W or more saturates whatever the rounding.
    always_comb
    begin
        pre_next = in_stage;
        for (int k = 0; k < LANES; k++)
        begin
            pre_next.ovf[k] = CMP_W'(in_stage.rem[k]) >= (CMP_W'(in_stage.den) << QUO_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= pre_next;
        end
    end

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - g;
        div_stage_t step_next;

        always_comb
        begin
            logic [CMP_W-1:0] sh;
            logic [CMP_W-1:0] rw;
            step_next = st_reg[g];
            sh = CMP_W'(st_reg[g].den) << BIT;
            for (int k = 0; k < LANES; k++)
            begin
                rw = CMP_W'(st_reg[g].rem[k]);
                if (rw >= sh)
                begin
                    rw = rw - sh;
                    step_next.rem[k] = rw[NUM_W-1:0];
                    step_next.quo[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[g+1] <= step_next;
            end
        end
    end

    always_comb
    begin
        logic [QUO_W:0]   qr;
        logic [QUO_W:0]   lim;
        logic             up;
        div_stage_t       fin;
        fin = st_reg[QUO_W];
        rnd_next.row  = fin.row;
        rnd_next.sing = fin.sing;
        rnd_next.neg  = fin.neg;
        for (int k = 0; k < LANES; k++)
        begin
            up  = (CMP_W'(fin.rem[k]) << 1) >= CMP_W'(fin.den);
            qr  = (QUO_W+1)'(fin.quo[k]) + (QUO_W+1)'(up);
            lim = fin.neg[k] ? (QUO_W+1)'(NEG_SAT) : (QUO_W+1)'(POS_SAT);
            rnd_next.sat[k] = fin.ovf[k] || (qr > lim);
            rnd_next.mag[k] = qr[ELEM_W-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (rnd_reg.sing)
            begin
                oval_next[k] = '0;
            end
            else if (rnd_reg.sat[k])
            begin
                oval_next[k] = rnd_reg.neg[k] ? NEG_SAT : POS_SAT;
            end
            else
            begin
                oval_next[k] = rnd_reg.neg[k] ? (~rnd_reg.mag[k] + 1'b1) : rnd_reg.mag[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_v_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (adv)
        begin
            rnd_v_reg <= vld_reg[QUO_W];
            ov_reg    <= rnd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rnd_reg   <= rnd_next;
            oval_reg  <= oval_next;
            orow_reg  <= rnd_reg.row;
            osing_reg <= rnd_reg.sing;
        end
    end

    assign out_valid = ov_reg;
    assign out_row   = orow_reg;
    assign out_vals  = oval_reg;
    assign out_sing  = osing_reg;
endmodule
`default_nettype wire

// ===== design/affine_3x4_inverse.sv =====
// ----------------------------------------------------------------------------
// affine_3x4_inverse
// Inverts one 3x4 affine transform in signed Q16.16 and returns the inverse
// as three row beats.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Beat contents
//   -------   --------------------   -----------------------------------------
//   in        in_valid / in_stall    nine linear elements and three shifts
//   out       out_valid / out_stall  row index, three elements, shift, flags
//
// Each transform yields three output beats back to back. The block takes a
// new transform only while the row sequencer is empty or issues the last
// row of the held one; that single sequencer feeds the four-lane divider
// one row per cycle while the output is not stalled.
// Reset is asynchronous and active low; it clears only valid and count flops.
// An output stall freezes every stage at once, and the input stall follows it.
//
`default_nettype none
module affine_3x4_inverse (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] row0_col0,
    input  logic [31:0] row0_col1,
    input  logic [31:0] row0_col2,
    input  logic [31:0] row1_col0,
    input  logic [31:0] row1_col1,
    input  logic [31:0] row1_col2,
    input  logic [31:0] row2_col0,
    input  logic [31:0] row2_col1,
    input  logic [31:0] row2_col2,
    input  logic [31:0] shift_x,
    input  logic [31:0] shift_y,
    input  logic [31:0] shift_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  row_index,
    output logic [31:0] inv_col0,
    output logic [31:0] inv_col1,
    output logic [31:0] inv_col2,
    output logic [31:0] inv_shift,
    output logic        singular,
    output logic        last_row
);
    import aff_pkg::*;

`include "affine_3x4_inverse_defines.svh"

    // Global advance: every stage moves unless the output beat is blocked.
    logic adv;
    // Front advance: the cofactor and determinant stages also wait for the
    // row sequencer to have room for a new transform.
    logic front_adv;

    logic [DIM*DIM-1:0][ELEM_W-1:0] elems;
    logic [DIM-1:0][ELEM_W-1:0]     shifts;

    logic       cof_valid;
    cof_item_t  cof_item;
    logic       det_valid;
    det_item_t  det_item;
    logic       seq_valid;
    div_stage_t seq_stage;
    logic [LANES-1:0][ELEM_W-1:0] vals;

    assign elems  = {row2_col2, row2_col1, row2_col0,
                     row1_col2, row1_col1, row1_col0,
                     row0_col2, row0_col1, row0_col0};
    assign shifts = {shift_z, shift_y, shift_x};

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !front_adv;

    // Minor products and cofactors of the linear part.
    aff_cofactor u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (front_adv),
        .in_valid  (in_valid),
        .elems     (elems),
        .shifts    (shifts),
        .out_valid (cof_valid),
        .out_item  (cof_item)
    );

    // Determinant and the adjugate times translation sums, exact.
    aff_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (front_adv),
        .in_valid  (cof_valid),
        .in_item   (cof_item),
        .out_valid (det_valid),
        .out_item  (det_item)
    );

    // Issues rows 0, 1 and 2 on consecutive advancing cycles.
    aff_row_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (det_valid),
        .in_item   (det_item),
        .front_adv (front_adv),
        .out_valid (seq_valid),
        .out_stage (seq_stage)
    );

    // Four quotients per row: three linear elements and the shift.
    aff_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (seq_valid),
        .in_stage  (seq_stage),
        .out_valid (out_valid),
        .out_row   (row_index),
        .out_vals  (vals),
        .out_sing  (singular)
    );

    assign inv_col0  = vals[0];
    assign inv_col1  = vals[1];
    assign inv_col2  = vals[2];
    assign inv_shift = vals[DIM];
    assign last_row  = (row_index == LAST_ROW);

    // A singular transform must come out as all zeros.
    `AFF_ASSERT_SAME(a_sing_zero, out_valid && singular,
                     inv_col0 == 0 && inv_col1 == 0 && inv_col2 == 0 && inv_shift == 0)
    // An input beat is only taken while the output side is moving.
    `AFF_ASSERT_SAME(a_in_follows_out, in_valid && !in_stall, !out_valid || !out_stall)
    // Rows of one transform leave back to back and in order.
    `AFF_ASSERT_NEXT(a_row_order, out_valid && !out_stall && !last_row,
                     out_valid && row_index == $past(row_index) + 2'd1)

endmodule
`default_nettype wire

// ===== bench/tb_affine_3x4_inverse.sv =====
// ----------------------------------------------------------------------------
// Affine 3x4 inverse testbench
// Sends 3x4 affine transforms through the block and checks every row beat it
// returns against an exact wide-integer prediction of the inverse. The run
// covers directed corner transforms and random ones under several idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One row beat of the inverse, as the block should present it.
typedef struct packed {
    logic [1:0]  row;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] shift;
    logic        sing;
    logic        last;
} inv_row_t;

// Nine linear elements in row-major order, then the x, y and z shifts.
typedef logic [31:0] xform_t [12];

typedef logic signed [191:0] wide_t;

class inverse_checker;
    inv_row_t inverse_rows[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    // Quotient rounded to nearest with ties away from zero, then saturated.
    function logic [31:0] round_div(input wide_t num, input wide_t den);
        logic        neg;
        logic [191:0] an;
        logic [191:0] dn;
        logic [191:0] q;
        logic [191:0] rm;
        logic [191:0] lim;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        dn = (den < 0) ? -den : den;
        q = an / dn;
        rm = an % dn;
        if ((rm << 1) >= dn)
        begin
            q = q + 1;
        end
        lim = neg ? 192'h8000_0000 : 192'h7fff_ffff;
        if (q > lim)
        begin
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // Notes an accepted transform and queues the three rows of its inverse.
    function void note_transform(input xform_t x);
        wide_t    m [3][3];
        wide_t    s [3];
        wide_t    adj [3][3];
        wide_t    det;
        wide_t    t;
        inv_row_t e;
        int       r1;
        int       r2;
        int       c1;
        int       c2;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m[r][c] = wide_t'($signed(x[r * 3 + c]));
            end
            s[r] = wide_t'($signed(x[9 + r]));
        end
        // The adjugate holds the cofactor of the transposed position.
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                r1 = (c + 1) % 3;
                r2 = (c + 2) % 3;
                c1 = (r + 1) % 3;
                c2 = (r + 2) % 3;
                adj[r][c] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
            end
        end
        det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
        for (int r = 0; r < 3; r++)
        begin
            e.row  = r[1:0];
            e.sing = (det == 0);
            e.last = (r == 2);
            e.col0 = '0;
            e.col1 = '0;
            e.col2 = '0;
            e.shift = '0;
            if (det != 0)
            begin
                e.col0 = round_div(adj[r][0] <<< 32, det);
                e.col1 = round_div(adj[r][1] <<< 32, det);
                e.col2 = round_div(adj[r][2] <<< 32, det);
                t = adj[r][0] * s[0] + adj[r][1] * s[1] + adj[r][2] * s[2];
                e.shift = round_div((-t) <<< 16, det);
            end
            inverse_rows.push_back(e);
        end
    endfunction

    // Compares one returned row beat with the oldest expected row.
    function void check_row(input inv_row_t a);
        inv_row_t e;
        if (inverse_rows.size() == 0)
        begin
            $display("%0t: row beat with nothing expected, row %0d", $time, a.row);
            errors++;
            return;
        end
        e = inverse_rows.pop_front();
        if (a != e)
        begin
            errors++;
            $display("%0t: mismatch expected row %0d %h %h %h shift %h sing %b last %b",
                     $time, e.row, e.col0, e.col1, e.col2, e.shift, e.sing, e.last);
            $display("%0t:          actual   row %0d %h %h %h shift %h sing %b last %b",
                     $time, a.row, a.col0, a.col1, a.col2, a.shift, a.sing, a.last);
        end
    endfunction
endclass

module tb_affine_3x4_inverse;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam logic [31:0] ONE   = 32'h0001_0000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] xin [12];
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  row_index;
    logic [31:0] inv_col0;
    logic [31:0] inv_col1;
    logic [31:0] inv_col2;
    logic [31:0] inv_shift;
    logic        singular;
    logic        last_row;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    inverse_checker chk;

    affine_3x4_inverse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .row0_col0 (xin[0]),
        .row0_col1 (xin[1]),
        .row0_col2 (xin[2]),
        .row1_col0 (xin[3]),
        .row1_col1 (xin[4]),
        .row1_col2 (xin[5]),
        .row2_col0 (xin[6]),
        .row2_col1 (xin[7]),
        .row2_col2 (xin[8]),
        .shift_x   (xin[9]),
        .shift_y   (xin[10]),
        .shift_z   (xin[11]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_index (row_index),
        .inv_col0  (inv_col0),
        .inv_col1  (inv_col1),
        .inv_col2  (inv_col2),
        .inv_shift (inv_shift),
        .singular  (singular),
        .last_row  (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // The receiver stalls at random; the stall is redrawn every cycle, which
    // lets stalls land on any of the three row beats of a transform.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Each accepted row beat is checked in arrival order.
    always @(posedge clk)
    begin
        inv_row_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            a.row = row_index;
            a.col0 = inv_col0;
            a.col1 = inv_col1;
            a.col2 = inv_col2;
            a.shift = inv_shift;
            a.sing = singular;
            a.last = last_row;
            chk.check_row(a);
        end
    end

    // The watchdog counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Presents one transform and holds it until the block takes the beat.
    // Valid is only lowered when an idle gap is drawn, so back-to-back beats
    // never see valid dropped and raised in the same step.
    task automatic send_transform(input xform_t x);
        for (int i = 0; i < 12; i++)
        begin
            xin[i] <= x[i];
        end
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        chk.note_transform(x);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < 50);
        end
    endtask

    task automatic wait_for_rows();
        in_valid <= 1'b0;
        while (chk.inverse_rows.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic xform_t diag(input logic [31:0] d0, input logic [31:0] d1,
                                    input logic [31:0] d2, input logic [31:0] sx,
                                    input logic [31:0] sy, input logic [31:0] sz);
        xform_t x;
        foreach (x[i])
        begin
            x[i] = '0;
        end
        x[0] = d0;
        x[4] = d1;
        x[8] = d2;
        x[9] = sx;
        x[10] = sy;
        x[11] = sz;
        return x;
    endfunction

    // Random transforms: mostly well conditioned ones near unit scale so the
    // inverse lands in range, plus raw bit patterns and singular matrices.
    function automatic xform_t random_transform();
        xform_t x;
        int     kind;
        kind = $urandom_range(9);
        foreach (x[i])
        begin
            x[i] = $urandom;
        end
        if (kind >= 3)
        begin
            for (int i = 0; i < 9; i++)
            begin
                x[i] = $signed($urandom_range(131072)) - 65536;
            end
            for (int i = 0; i < 3; i++)
            begin
                x[i * 4] = $urandom_range(262144, 32768);
                if ($urandom_range(1))
                begin
                    x[i * 4] = -x[i * 4];
                end
            end
            for (int i = 9; i < 12; i++)
            begin
                x[i] = $signed(x[i]) >>> $urandom_range(31);
            end
        end
        else if (kind == 2)
        begin
            // Third row repeats the first, so the determinant is zero.
            x[6] = x[0];
            x[7] = x[1];
            x[8] = x[2];
        end
        return x;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_transform(random_transform());
        end
    endtask

    initial
    begin
        xform_t x;
        chk = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        foreach (xin[i])
        begin
            xin[i] = '0;
        end
        send_idle_pct = 16;
        recv_idle_pct = 46;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: identity, zero, uniform extremes, tiny and huge
        // diagonals that saturate, rounding of thirds, a permutation and a
        // singular matrix with nonzero shifts.
        send_transform(diag(ONE, ONE, ONE, 0, 0, 0));
        send_transform(diag(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, ONE));
        send_transform(diag(32'd1, 32'd1, 32'd1, ONE, -ONE, 32'h7fff_ffff));
        send_transform(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
        send_transform(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_transform(diag(3 * ONE, -3 * ONE, 2 * ONE, ONE, ONE, ONE));
        send_transform(diag(32'h0002_0000, 32'h0000_8000, -ONE, 32'h0001_8000,
                            32'h0000_0001, 32'hffff_ffff));
        x = diag(0, 0, 0, 5 * ONE, 7 * ONE, -9 * ONE);
        x[1] = ONE;
        x[5] = -ONE;
        x[6] = ONE;
        send_transform(x);
        foreach (x[i])
        begin
            x[i] = 32'h7fff_ffff;
        end
        send_transform(x);
        foreach (x[i])
        begin
            x[i] = 32'h8000_0000;
        end
        send_transform(x);
        foreach (x[i])
        begin
            x[i] = 32'hffff_ffff;
        end
        x[0] = 32'h0;
        x[4] = 32'h0;
        send_transform(x);
        x = diag(ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE);
        x[6] = ONE;
        x[7] = 2 * ONE;
        x[8] = 3 * ONE;
        x[0] = ONE;
        x[1] = 2 * ONE;
        x[2] = 3 * ONE;
        send_transform(x);
        x = diag(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                 32'h5555_5555, 32'haaaa_aaaa, 32'hf0f0_f0f0);
        x[1] = 32'hf0f0_f0f0;
        x[3] = 32'h3333_3333;
        x[5] = 32'hcccc_cccc;
        x[7] = 32'h0ff0_0ff0;
        send_transform(x);

        // Hold the sender off until every row has drained once.
        wait_for_rows();

        run_random(117);
        send_idle_pct = 46;
        recv_idle_pct = 16;
        run_random(117);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(116);

        wait_for_rows();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk.errors == 0 && chk.inverse_rows.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/aff_pkg.sv
design/aff_cofactor.sv
design/aff_det.sv
design/aff_row_seq.sv
design/aff_divider.sv
design/affine_3x4_inverse.sv
bench/tb_affine_3x4_inverse.sv
